@@ src/bsd_pkg.sv @@
// Shared types and constants for the 24-bit BMP stream decoder.
package bsd_pkg;

   localparam int MAX_DIM_DEF = 4096;

   localparam logic [15:0] BMP_MAGIC     = 16'h4D42;
   localparam logic [31:0] INFO_SIZE_OK  = 32'd40;
   localparam logic [15:0] DEPTH_OK      = 16'd24;
   localparam logic [5:0]  FILE_HDR_LAST = 6'd13;   // index of byte 14
   localparam logic [5:0]  HDR_LAST      = 6'd53;   // index of byte 54

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_MAGIC = 3'd1,
      ST_BAD_INFO  = 3'd2,
      ST_BAD_BPP   = 3'd3,
      ST_ZERO_SIZE = 3'd4,
      ST_TRUNC     = 3'd5,
      ST_TOO_LARGE = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_PIXEL  = 4'b0010,
      PH_PAD    = 4'b0100,
      PH_DROP   = 4'b1000
   } phase_type;

   // header parser view, valid for the beat currently offered
   typedef struct packed {
      logic       in_file_hdr;   // this beat is one of the first 13 bytes
      logic       file_end;      // this beat is byte 14
      logic       hdr_end;       // this beat is byte 54
      logic       magic_ok;
      status_type code;          // header check result, meaningful on hdr_end
      logic [1:0] pad;           // padding bytes per row
   } hdr_info_type;

endpackage

@@ src/bmp24_stream_decoder.sv @@
// Top level of the streaming 24-bit BMP decoder.
//
//  channel | direction | beat contents                          | handshake
//  req     | in        | data_byte, last_byte                   | req_valid / req_stall
//  rsp     | out       | result_kind, status, rgb, column, row,  | rsp_valid / rsp_stall
//          |           | last_pixel                             |
//
// One byte is taken per cycle while req_stall is low; a result appears in
// the cycle after the byte that completes it. All decode work sits between
// the byte and the result register, so with no stall the rate is one beat per cycle.
// reset is synchronous and returns the parser to the start of a file.
// req_stall is raised only while a result is held and rsp_stall is high.
module bmp24_stream_decoder import bsd_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic        rsp_last_pixel
);

   localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   phase_type          phase_ff, phase_in;
   logic [1:0]         bip_ff, bip_in;
   logic [1:0]         pad_ff, pad_in;
   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [7:0]         blue_ff, green_ff;
   logic               rsp_valid_ff;
   logic               rsp_kind_ff, rsp_last_ff;
   status_type         rsp_status_ff;
   logic [7:0]         rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [11:0]        rsp_col_ff, rsp_row_ff;

   logic               take;
   logic               hdr_clear;
   logic               emit, emit_err, emit_final;
   status_type         err_code;
   logic               at_row_end;
   hdr_info_type       hdr_info;
   logic [CNT_W-1:0]   width_m1, height_m1;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   bsd_header #(.MAX_DIM(MAX_DIM)) u_header (
      .clock     (clock),
      .reset     (reset),
      .hdr_take  (take && phase_ff == PH_HEADER),
      .hdr_clear (hdr_clear),
      .data_byte (req_data_byte),
      .hdr_info  (hdr_info),
      .width_m1  (width_m1),
      .height_m1 (height_m1)
   );

   assign at_row_end = (col_ff == width_m1);

   always_comb begin
      phase_in   = phase_ff;
      bip_in     = bip_ff;
      pad_in     = pad_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      hdr_clear  = 1'b0;
      emit       = 1'b0;
      emit_err   = 1'b0;
      emit_final = 1'b0;
      err_code   = ST_OK;

      if (take) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_info.file_end && !hdr_info.magic_ok) begin
                  emit_err = 1'b1;
                  err_code = ST_BAD_MAGIC;
               end else if (hdr_info.hdr_end) begin
                  if (hdr_info.code != ST_OK) begin
                     emit_err = 1'b1;
                     err_code = hdr_info.code;
                  end else if (req_last_byte) begin
                     emit_err = 1'b1;
                     err_code = ST_TRUNC;
                  end else begin
                     phase_in = PH_PIXEL;
                     col_in   = '0;
                     row_in   = height_m1;
                     bip_in   = 2'd0;
                     pad_in   = 2'd0;
                  end
               end else if (req_last_byte) begin
                  emit_err = 1'b1;
                  err_code = hdr_info.in_file_hdr ? ST_BAD_MAGIC : ST_BAD_INFO;
               end
            end
            PH_PIXEL: begin
               if (bip_ff != 2'd2) begin
                  bip_in = bip_ff + 2'd1;
                  if (req_last_byte) begin
                     emit_err = 1'b1;
                     err_code = ST_TRUNC;
                  end
               end else begin
                  bip_in = 2'd0;
                  if (at_row_end && row_ff == '0) begin
                     emit       = 1'b1;
                     emit_final = 1'b1;
                     phase_in   = PH_DROP;
                  end else if (req_last_byte) begin
                     emit_err = 1'b1;
                     err_code = ST_TRUNC;
                  end else begin
                     emit = 1'b1;
                     if (at_row_end) begin
                        col_in = '0;
                        row_in = row_ff - 1'b1;
                        pad_in = hdr_info.pad;
                        if (hdr_info.pad != 2'd0) begin
                           phase_in = PH_PAD;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
            end
            PH_PAD: begin
               pad_in = pad_ff - 2'd1;
               if (pad_in == 2'd0) begin
                  phase_in = PH_PIXEL;
               end
               if (req_last_byte) begin
                  emit_err = 1'b1;
                  err_code = ST_TRUNC;
               end
            end
            default: begin
               // drop phase: nothing to do until the end of the file
            end
         endcase

         if (emit_err) begin
            emit     = 1'b1;
            phase_in = PH_DROP;
         end
         // end of file always rearms, whatever happened on this beat
         if (req_last_byte) begin
            phase_in  = PH_HEADER;
            hdr_clear = 1'b1;
            bip_in    = 2'd0;
            pad_in    = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         bip_ff   <= '0;
         pad_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         bip_ff   <= bip_in;
         pad_ff   <= pad_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && phase_ff == PH_PIXEL) begin
         if (bip_ff == 2'd0) begin
            blue_ff <= req_data_byte;
         end
         if (bip_ff == 2'd1) begin
            green_ff <= req_data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (emit_err) begin
            rsp_kind_ff   <= KIND_ERROR;
            rsp_status_ff <= err_code;
            rsp_red_ff    <= '0;
            rsp_green_ff  <= '0;
            rsp_blue_ff   <= '0;
            rsp_col_ff    <= '0;
            rsp_row_ff    <= '0;
            rsp_last_ff   <= 1'b0;
         end else begin
            rsp_kind_ff   <= KIND_PIXEL;
            rsp_status_ff <= ST_OK;
            rsp_red_ff    <= req_data_byte;
            rsp_green_ff  <= green_ff;
            rsp_blue_ff   <= blue_ff;
            rsp_col_ff    <= 12'(col_ff);
            rsp_row_ff    <= 12'(row_ff);
            rsp_last_ff   <= emit_final;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_column      = rsp_col_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule

@@ src/bsd_header.sv @@
// Header byte collector and field checks for the BMP stream decoder.
module bsd_header import bsd_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               hdr_take,
   input  logic               hdr_clear,
   input  logic [7:0]         data_byte,
   output hdr_info_type       hdr_info,
   output logic [CNT_W-1:0]   width_m1,
   output logic [CNT_W-1:0]   height_m1
);

   logic [5:0]  count_ff, count_in;
   logic [15:0] magic_ff;
   logic [31:0] info_size_ff;
   logic [31:0] width_ff;
   logic [31:0] height_ff;
   logic [15:0] depth_ff;
   status_type  code;

   always_comb begin
      count_in = count_ff;
      if (hdr_clear) begin
         count_in = '0;
      end else if (hdr_take) begin
         count_in = count_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // every field byte is written once per file before any check reads it
   always_ff @(posedge clock) begin
      if (hdr_take) begin
         if (count_ff < 6'd2) begin
            magic_ff[8*count_ff[0] +: 8] <= data_byte;
         end else if (count_ff >= 6'd14 && count_ff < 6'd18) begin
            info_size_ff[8*2'(count_ff - 6'd14) +: 8] <= data_byte;
         end else if (count_ff >= 6'd18 && count_ff < 6'd22) begin
            width_ff[8*2'(count_ff - 6'd18) +: 8] <= data_byte;
         end else if (count_ff >= 6'd22 && count_ff < 6'd26) begin
            height_ff[8*2'(count_ff - 6'd22) +: 8] <= data_byte;
         end else if (count_ff >= 6'd28 && count_ff < 6'd30) begin
            depth_ff[8*count_ff[0] +: 8] <= data_byte;
         end
      end
   end

   always_comb begin
      if (info_size_ff != INFO_SIZE_OK) begin
         code = ST_BAD_INFO;
      end else if (depth_ff != DEPTH_OK) begin
         code = ST_BAD_BPP;
      end else if (width_ff == '0 || height_ff == '0) begin
         code = ST_ZERO_SIZE;
      end else if (width_ff > 32'(MAX_DIM) || height_ff > 32'(MAX_DIM)) begin
         code = ST_TOO_LARGE;
      end else begin
         code = ST_OK;
      end
   end

   assign hdr_info.in_file_hdr = (count_ff < FILE_HDR_LAST);
   assign hdr_info.file_end    = (count_ff == FILE_HDR_LAST);
   assign hdr_info.hdr_end     = (count_ff == HDR_LAST);
   assign hdr_info.magic_ok    = (magic_ff == BMP_MAGIC);
   assign hdr_info.code        = code;
   // (4 - 3w mod 4) mod 4 reduces to w mod 4
   assign hdr_info.pad         = width_ff[1:0];

   assign width_m1  = CNT_W'(width_ff - 32'd1);
   assign height_m1 = CNT_W'(height_ff - 32'd1);

endmodule

@@ verif/tb_bmp24_stream_decoder.sv @@
// Self-checking testbench for the streaming 24-bit BMP decoder.
`timescale 1ns / 100ps

module tb_bmp24_stream_decoder;
   import bsd_pkg::*;

   localparam int NO_CUT      = -1;
   localparam int NO_ERR      = -1;
   localparam int PIX_CAP     = 4096;   // largest pixel count a generated file carries
   localparam int ITEM_TARGET = 1600;   // random files are added until the stream is this long
   localparam int PRESS_FILE  = 5;      // the cut 4096-wide image takes the long rsp hold-off
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_DIR     = 27;

   typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   // one file of the stream: header fields, where last_byte cuts it, and any
   // error code known up front together with the byte that raises it
   typedef struct packed {
      logic [31:0] width;
      logic [31:0] height;
      logic [15:0] magic;
      logic [31:0] info;
      logic [15:0] bpp;
      int          cut;
      int          tail;
      int          err_at;
      status_type  code;
      fill_type    fill;
   } file_case_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         typed;
      status_type code;
      int         file_no;
   } byte_item_type;

   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] column;
      logic [11:0] row;
      logic        last_pixel;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [11:0] rsp_column;
   logic [11:0] rsp_row;
   logic        rsp_last_pixel;

   bmp24_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_status      (rsp_status),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_column      (rsp_column),
      .rsp_row         (rsp_row),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   always #10 clock = ~clock;

   // w, h, magic, info size, bpp, cut, tail, error byte, error code, pixel fill
   file_case_type dir_cases [NUM_DIR] = '{
      '{1, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 0, NO_ERR, ST_OK, FILL_ONES},
      '{1, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 3, NO_ERR, ST_OK, FILL_ZERO},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 0, NO_ERR, ST_OK, FILL_RANDOM},
      '{3, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 0, NO_ERR, ST_OK, FILL_RANDOM},
      '{4, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 0, NO_ERR, ST_OK, FILL_RANDOM},
      '{4096, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 77, 0, NO_ERR, ST_OK, FILL_RANDOM},
      '{1, 4096, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 65, 0, NO_ERR, ST_OK, FILL_RANDOM},
      '{2, 1, 16'h4D43, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 4, 13, ST_BAD_MAGIC, FILL_RANDOM},
      '{2, 1, 16'h424D, INFO_SIZE_OK, DEPTH_OK, 13, 0, 13, ST_BAD_MAGIC, FILL_RANDOM},
      '{2, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 5, 0, 5, ST_BAD_MAGIC, FILL_RANDOM},
      '{2, 1, 16'hFFFF, INFO_SIZE_OK, DEPTH_OK, 0, 0, 0, ST_BAD_MAGIC, FILL_RANDOM},
      '{2, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 13, 0, 13, ST_BAD_INFO, FILL_RANDOM},
      '{2, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 30, 0, 30, ST_BAD_INFO, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, 32'd41, DEPTH_OK, NO_CUT, 2, 53, ST_BAD_INFO, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, 32'hFFFF_FFFF, 16'd32, NO_CUT, 0, 53, ST_BAD_INFO, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, 16'd32, NO_CUT, 1, 53, ST_BAD_BPP, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, 16'h8018, NO_CUT, 0, 53, ST_BAD_BPP, FILL_RANDOM},
      '{0, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 1, 53, ST_ZERO_SIZE, FILL_RANDOM},
      '{2, 0, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 1, 53, ST_ZERO_SIZE, FILL_RANDOM},
      '{0, 5000, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 1, 53, ST_ZERO_SIZE, FILL_RANDOM},
      '{4097, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 2, 53, ST_TOO_LARGE, FILL_RANDOM},
      '{2, 32'hFFFF_FFFF, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, NO_CUT, 2, 53, ST_TOO_LARGE,
        FILL_RANDOM},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 53, 0, 53, ST_TRUNC, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 55, 0, 55, ST_TRUNC, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 59, 0, 59, ST_TRUNC, FILL_RANDOM},
      '{2, 2, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 60, 0, 60, ST_TRUNC, FILL_RANDOM},
      '{1, 1, BMP_MAGIC, INFO_SIZE_OK, DEPTH_OK, 56, 0, NO_ERR, ST_OK, FILL_RANDOM}
   };

   byte_item_type stim_q [$];
   decoded_type   pending_q [$];
   int            file_total = 0;
   int            send_idx = 0;
   int            fail_count = 0;
   int            pixels_checked = 0;
   int            errors_checked = 0;
   int            quiet_cycles = 0;
   int            hold_left = 0;
   bit            hold_done = 1'b0;

   // decoder shadow state
   phase_type   p_phase;
   logic [5:0]  p_hdr_idx;
   logic [15:0] p_magic;
   logic [31:0] p_info_size;
   logic [31:0] p_width;
   logic [31:0] p_height;
   logic [15:0] p_depth;
   logic [11:0] p_col;
   logic [11:0] p_row;
   logic [1:0]  p_sub;
   logic [7:0]  p_blue;
   logic [7:0]  p_green;
   logic [1:0]  p_pad;

   task automatic clear_parser();
      p_phase     = PH_HEADER;
      p_hdr_idx   = '0;
      p_magic     = '0;
      p_info_size = '0;
      p_width     = '0;
      p_height    = '0;
      p_depth     = '0;
      p_col       = '0;
      p_row       = '0;
      p_sub       = '0;
      p_blue      = '0;
      p_green     = '0;
      p_pad       = '0;
   endtask

   task automatic raise_error(input status_type code, input logic last, output decoded_type res);
      res = '0;
      res.kind = KIND_ERROR;
      res.status = code;
      if (last) clear_parser();
      else p_phase = PH_DROP;
   endtask

   task automatic decode_beat(input logic [7:0] b, input logic last,
                              output bit got, output decoded_type res);
      int k;
      int n;
      bit final_px;
      got = 1'b0;
      res = '0;
      case (p_phase)
         PH_HEADER: begin
            k = p_hdr_idx;
            n = k + 1;
            if (k < 2) p_magic[8*k +: 8] = b;
            else if (k >= 14 && k < 18) p_info_size[8*(k-14) +: 8] = b;
            else if (k >= 18 && k < 22) p_width[8*(k-18) +: 8] = b;
            else if (k >= 22 && k < 26) p_height[8*(k-22) +: 8] = b;
            else if (k >= 28 && k < 30) p_depth[8*(k-28) +: 8] = b;
            p_hdr_idx = 6'(n);
            if (n < 14) begin
               if (last) begin
                  raise_error(ST_BAD_MAGIC, 1'b1, res);
                  got = 1'b1;
               end
            end else if (n == 14) begin
               if (p_magic != BMP_MAGIC) begin
                  raise_error(ST_BAD_MAGIC, last, res);
                  got = 1'b1;
               end else if (last) begin
                  raise_error(ST_BAD_INFO, 1'b1, res);
                  got = 1'b1;
               end
            end else if (n < 54) begin
               if (last) begin
                  raise_error(ST_BAD_INFO, 1'b1, res);
                  got = 1'b1;
               end
            end else begin
               got = 1'b1;
               if (p_info_size != INFO_SIZE_OK) raise_error(ST_BAD_INFO, last, res);
               else if (p_depth != DEPTH_OK) raise_error(ST_BAD_BPP, last, res);
               else if (p_width == 0 || p_height == 0) raise_error(ST_ZERO_SIZE, last, res);
               else if (p_width > MAX_DIM_DEF || p_height > MAX_DIM_DEF)
                  raise_error(ST_TOO_LARGE, last, res);
               else if (last) raise_error(ST_TRUNC, 1'b1, res);
               else begin
                  got     = 1'b0;
                  p_phase = PH_PIXEL;
                  p_col   = '0;
                  p_row   = 12'(p_height - 1);
                  p_sub   = '0;
                  p_pad   = '0;
               end
            end
         end
         PH_PIXEL: begin
            if (p_sub == 2'd0) begin
               p_blue = b;
               p_sub  = 2'd1;
               if (last) begin
                  raise_error(ST_TRUNC, 1'b1, res);
                  got = 1'b1;
               end
            end else if (p_sub == 2'd1) begin
               p_green = b;
               p_sub   = 2'd2;
               if (last) begin
                  raise_error(ST_TRUNC, 1'b1, res);
                  got = 1'b1;
               end
            end else begin
               p_sub = 2'd0;
               final_px = ({20'd0, p_col} == p_width - 1) && (p_row == 12'd0);
               got = 1'b1;
               res.kind       = KIND_PIXEL;
               res.status     = ST_OK;
               res.red        = b;
               res.green      = p_green;
               res.blue       = p_blue;
               res.column     = p_col;
               res.row        = p_row;
               res.last_pixel = final_px;
               if (final_px) begin
                  if (last) clear_parser();
                  else p_phase = PH_DROP;
               end else if (last) begin
                  raise_error(ST_TRUNC, 1'b1, res);
               end else if ({20'd0, p_col} + 1 >= p_width) begin
                  p_col = '0;
                  p_row = p_row - 12'd1;
                  p_pad = 2'(4 - ((p_width * 3) & 3));
                  if (p_pad != 2'd0) p_phase = PH_PAD;
               end else begin
                  p_col = p_col + 12'd1;
               end
            end
         end
         PH_PAD: begin
            p_pad = p_pad - 2'd1;
            if (p_pad == 2'd0) p_phase = PH_PIXEL;
            if (last) begin
               raise_error(ST_TRUNC, 1'b1, res);
               got = 1'b1;
            end
         end
         default: begin
            if (last) clear_parser();
         end
      endcase
   endtask

   // Builds one file as a byte list and queues it.
   task automatic add_bmp_file(input file_case_type c);
      logic [7:0] fbytes [$];
      logic [7:0] hdr [54];
      logic [7:0] px;
      byte_item_type item;
      bit dims_ok;
      bit has_pix;
      int pad;
      int i;
      int r;
      for (i = 0; i < 54; i++) hdr[i] = 8'($urandom_range(0, 255));
      hdr[0] = c.magic[7:0];
      hdr[1] = c.magic[15:8];
      for (i = 0; i < 4; i++) begin
         hdr[14+i] = c.info[8*i +: 8];
         hdr[18+i] = c.width[8*i +: 8];
         hdr[22+i] = c.height[8*i +: 8];
      end
      hdr[28] = c.bpp[7:0];
      hdr[29] = c.bpp[15:8];
      foreach (hdr[j]) fbytes.push_back(hdr[j]);

      dims_ok = c.width >= 1 && c.width <= MAX_DIM_DEF && c.height >= 1 &&
                c.height <= MAX_DIM_DEF;
      has_pix = dims_ok && (c.width * c.height <= PIX_CAP);
      if (has_pix) begin
         pad = (4 - ((c.width * 3) & 3)) & 3;
         for (r = 0; r < c.height; r++) begin
            for (i = 0; i < 3 * c.width; i++) begin
               case (c.fill)
                  FILL_ZERO: px = 8'h00;
                  FILL_ONES: px = 8'hFF;
                  default:   px = 8'($urandom_range(0, 255));
               endcase
               fbytes.push_back(px);
            end
            for (i = 0; i < pad; i++) fbytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      for (i = 0; i < c.tail; i++) fbytes.push_back(8'($urandom_range(0, 255)));
      if (c.cut >= 0)
         while (fbytes.size() > c.cut + 1) void'(fbytes.pop_back());

      foreach (fbytes[j]) begin
         item.data    = fbytes[j];
         item.last    = (j == fbytes.size() - 1);
         item.typed   = (j == c.err_at);
         item.code    = c.code;
         item.file_no = file_total;
         stim_q.push_back(item);
      end
      file_total++;
   endtask

   function automatic int current_file();
      return (send_idx < stim_q.size()) ? stim_q[send_idx].file_no : -1;
   endfunction

   // 0: sender idles 21%, receiver 51%; 1: the other way; 2: no idling
   function automatic int idle_mode();
      return (current_file() < 0) ? 2 : current_file() * 3 / file_total;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [11:0] got,
                              input logic [11:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // rsp checking first, then req accept/drive, all in one edge-ordered block
   always @(posedge clock) begin : beat_traffic
      decoded_type   e;
      decoded_type   res;
      bit            got;
      int            nxt;
      int            pct;
      byte_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         clear_parser();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               e = pending_q.pop_front();
               check_field("result_kind", 12'(rsp_result_kind), 12'(e.kind));
               check_field("status", 12'(rsp_status), 12'(e.status));
               check_field("red", 12'(rsp_red), 12'(e.red));
               check_field("green", 12'(rsp_green), 12'(e.green));
               check_field("blue", 12'(rsp_blue), 12'(e.blue));
               check_field("column", rsp_column, e.column);
               check_field("row", rsp_row, e.row);
               check_field("last_pixel", 12'(rsp_last_pixel), 12'(e.last_pixel));
               if (e.kind == KIND_ERROR) errors_checked++;
               else pixels_checked++;
            end
         end

         nxt = send_idx;
         if (req_valid && !req_stall) begin
            item = stim_q[send_idx];
            decode_beat(item.data, item.last, got, res);
            if (item.typed) begin
               res = '0;
               res.kind = KIND_ERROR;
               res.status = item.code;
               got = 1'b1;
            end
            if (got) pending_q.push_back(res);
            nxt = send_idx + 1;
         end
         case (idle_mode())
            0:       pct = 21;
            1:       pct = 51;
            default: pct = 0;
         endcase
         if (req_valid && req_stall) begin
            // held beat stays as it is
         end else if (nxt < stim_q.size() && $urandom_range(0, 99) >= pct) begin
            req_valid     <= 1'b1;
            req_data_byte <= stim_q[nxt].data;
            req_last_byte <= stim_q[nxt].last;
         end else begin
            req_valid <= 1'b0;
         end
         send_idx <= nxt;
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      int pct;
      case (idle_mode())
         0:       pct = 51;
         1:       pct = 21;
         default: pct = 0;
      endcase
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && current_file() == PRESS_FILE) begin
         // long hold-off so the result register fills and req_stall backs up
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no beat for %0d cycles, %0d results outstanding",
                     $realtime, QUIET_LIMIT, pending_q.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      file_case_type c;
      int sel;
      int pad;
      clear_parser();
      foreach (dir_cases[i]) add_bmp_file(dir_cases[i]);

      while (stim_q.size() < ITEM_TARGET) begin
         c.width  = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
         c.height = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
         c.magic  = BMP_MAGIC;
         c.info   = INFO_SIZE_OK;
         c.bpp    = DEPTH_OK;
         c.cut    = NO_CUT;
         c.tail   = $urandom_range(0, 3);
         c.err_at = NO_ERR;
         c.code   = ST_OK;
         c.fill   = FILL_RANDOM;
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            // well-formed file
         end else if (sel < 78) begin
            pad = (4 - ((c.width * 3) & 3)) & 3;
            c.cut = $urandom_range(0, 54 + c.height * (3 * c.width + pad) - 1);
         end else if (sel < 81) begin
            c.magic = 16'($urandom_range(0, 65535));
         end else if (sel < 84) begin
            c.info = ($urandom_range(0, 1) != 0) ? $urandom() :
                     INFO_SIZE_OK ^ (32'd1 << $urandom_range(0, 31));
         end else if (sel < 87) begin
            c.bpp = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535)) :
                    DEPTH_OK ^ (16'd1 << $urandom_range(0, 15));
         end else if (sel < 90) begin
            if ($urandom_range(0, 1) != 0) c.width = 0;
            if ($urandom_range(0, 1) != 0) c.height = 0;
            else if (c.width != 0) c.width = 0;
         end else if (sel < 94) begin
            if ($urandom_range(0, 1) != 0) c.width = MAX_DIM_DEF + 1 + $urandom_range(0, 200);
            else c.height = $urandom();
         end else begin
            // noise: random header fields, random early end
            c.magic  = 16'($urandom_range(0, 65535));
            c.info   = $urandom();
            c.width  = $urandom();
            c.height = $urandom();
            c.bpp    = 16'($urandom_range(0, 65535));
            c.cut    = $urandom_range(0, 60);
         end
         add_bmp_file(c);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (send_idx < stim_q.size() || pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d files in %0d bytes; checked %0d pixel and %0d error beats.",
               file_total, stim_q.size(), pixels_checked, errors_checked);
      $display("Covered header checks, truncation, row padding 0-3, max size %0d: %0d errs.",
               MAX_DIM_DEF, fail_count);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
